[hdl/npr_pkg.sv]
// Shared constants, codes and types of the nearest palette remap unit.
package npr_pkg;

    localparam int TARGET_COLORS = 256;
    localparam int SOURCE_COLORS = 256;

    localparam int IDX_W   = 8;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;
    localparam int COUNT_W = 9;

    localparam logic [COUNT_W-1:0] TARGET_COUNT_RESET = COUNT_W'(TARGET_COLORS);

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_MATCH = 2'd1,
        REQ_PIXEL = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic {
        KIND_MATCH = 1'b0,
        KIND_PIXEL = 1'b1
    } t_kind;

    // Tag that travels with one target entry through the distance pipeline.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_search_tag;

endpackage

[hdl/npr_target_ram.sv]
// Target palette memory: one write port, one registered read port.
module npr_target_ram (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [npr_pkg::IDX_W-1:0]   i_wr_addr,
    input  logic [npr_pkg::COLOR_W-1:0] i_wr_data,
    input  logic [npr_pkg::IDX_W-1:0]   i_rd_addr,
    output logic [npr_pkg::COLOR_W-1:0] o_rd_data
);
    import npr_pkg::*;

    logic [COLOR_W-1:0] r_mem [TARGET_COLORS];
    logic [COLOR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/npr_remap_ram.sv]
// Remap table memory with per-entry valid bits so it reads zero after reset.
module npr_remap_ram (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [npr_pkg::IDX_W-1:0] i_wr_addr,
    input  logic [npr_pkg::IDX_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [npr_pkg::IDX_W-1:0] i_rd_addr,
    output logic [npr_pkg::IDX_W-1:0] o_rd_data
);
    import npr_pkg::*;

    logic [IDX_W-1:0] r_mem [SOURCE_COLORS];
    logic [SOURCE_COLORS-1:0] r_valid;
    logic [IDX_W-1:0] r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

[hdl/npr_dist_unit.sv]
// Squared RGB distance pipeline and running minimum over one search.
module npr_dist_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  npr_pkg::t_search_tag        i_tag,
    input  logic [npr_pkg::COLOR_W-1:0] i_entry,
    input  logic [npr_pkg::CHAN_W-1:0]  i_red,
    input  logic [npr_pkg::CHAN_W-1:0]  i_green,
    input  logic [npr_pkg::CHAN_W-1:0]  i_blue,
    output logic [npr_pkg::IDX_W-1:0]   o_best_idx,
    output logic [npr_pkg::DIST_W-1:0]  o_best_dist,
    output logic                        o_done
);
    import npr_pkg::*;

    logic signed [CHAN_W:0]     diff_r, diff_g, diff_b;
    logic signed [2*CHAN_W+1:0] prod_r, prod_g, prod_b;
    logic [DIST_W-1:0]          sum;

    t_search_tag       r_tag;
    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
    logic [IDX_W-1:0]  r_best_idx;
    logic [DIST_W-1:0] r_best_dist;
    logic              r_done;

    assign diff_r = $signed({1'b0, i_red})   - $signed({1'b0, i_entry[3*CHAN_W-1:2*CHAN_W]});
    assign diff_g = $signed({1'b0, i_green}) - $signed({1'b0, i_entry[2*CHAN_W-1:CHAN_W]});
    assign diff_b = $signed({1'b0, i_blue})  - $signed({1'b0, i_entry[CHAN_W-1:0]});
    assign prod_r = diff_r * diff_r;
    assign prod_g = diff_g * diff_g;
    assign prod_b = diff_b * diff_b;

    assign sum = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        r_sq_r <= prod_r[SQ_W-1:0];
        r_sq_g <= prod_g[SQ_W-1:0];
        r_sq_b <= prod_b[SQ_W-1:0];
        // first entry loads unconditionally; later ones only when strictly closer
        if (r_tag.valid && (r_tag.first || (sum < r_best_dist))) begin
            r_best_dist <= sum;
            r_best_idx  <= r_tag.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag  <= '0;
            r_done <= 1'b0;
        end else begin
            r_tag  <= i_tag;
            r_done <= r_tag.valid && r_tag.last;
        end
    end

    assign o_best_idx  = r_best_idx;
    assign o_best_dist = r_best_dist;
    assign o_done      = r_done;

endmodule

[hdl/nearest_palette_remap_unit.sv]
// Top level of the nearest palette remap unit: request sequencer and output register.
//
//   channel  handshake                 payload
//   cfg      i_cfg_valid / o_cfg_ready i_cfg_data (target_count)
//   in       i_in_valid / o_in_stall   i_req_type, i_entry_index, i_red, i_green,
//                                      i_blue, i_pixel_index, i_last_in
//   out      o_out_valid / i_out_stall o_kind, o_color_index, o_distance, o_last_out
//
// A target load is written when it is accepted. A pixel remap reads the remap memory,
// then emits from the emit state. A match reads one target memory entry per cycle in
// the scan state, drains the pipeline (memory read, squares, compare) in the drain
// state, then stores and emits the result in the emit state.
// Reset clears the remap table valid bits and sets target_count to 256.
// A stalled output holds the finished result; new items are taken meanwhile in idle.
module nearest_palette_remap_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [npr_pkg::COUNT_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [npr_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [npr_pkg::CHAN_W-1:0]  i_red,
    input  logic [npr_pkg::CHAN_W-1:0]  i_green,
    input  logic [npr_pkg::CHAN_W-1:0]  i_blue,
    input  logic [npr_pkg::IDX_W-1:0]   i_pixel_index,
    input  logic                        i_last_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_kind,
    output logic [npr_pkg::IDX_W-1:0]   o_color_index,
    output logic [npr_pkg::DIST_W-1:0]  o_distance,
    output logic                        o_last_out
);
    import npr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_target_count;
    logic [IDX_W-1:0]   r_last_idx;
    logic [IDX_W-1:0]   r_scan_idx;
    t_search_tag        r_tag, n_tag;
    t_kind              r_kind;
    logic [IDX_W-1:0]   r_src_idx;
    logic               r_src_ok;
    logic               r_pix_ok;
    logic [CHAN_W-1:0]  r_red, r_green, r_blue;
    logic               r_last;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [IDX_W-1:0]   r_out_index;
    logic [DIST_W-1:0]  r_out_dist;
    logic               r_out_last;

    logic               in_accept;
    t_req               req;
    logic [COUNT_W-1:0] count_clamped;
    logic               out_free;
    logic               emit;
    logic [COLOR_W-1:0] target_rd_data;
    logic [IDX_W-1:0]   remap_rd_data;
    logic [IDX_W-1:0]   best_idx;
    logic [DIST_W-1:0]  best_dist;
    logic               search_done;

    assign req        = t_req'(i_req_type);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign emit       = (r_state == S_EMIT) && out_free;

    always_comb begin
        if (r_target_count == '0) begin
            count_clamped = COUNT_W'(1);
        end else if (r_target_count > COUNT_W'(TARGET_COLORS)) begin
            count_clamped = COUNT_W'(TARGET_COLORS);
        end else begin
            count_clamped = r_target_count;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && req == REQ_MATCH) begin
                    n_state = S_SCAN;
                end else if (in_accept && req == REQ_PIXEL) begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                if (r_scan_idx == r_last_idx) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (search_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_tag       = '0;
        n_tag.valid = (r_state == S_SCAN);
        n_tag.first = (r_scan_idx == '0);
        n_tag.last  = (r_scan_idx == r_last_idx);
        n_tag.idx   = r_scan_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_target_count <= TARGET_COUNT_RESET;
            r_out_valid    <= 1'b0;
            r_tag          <= '0;
        end else begin
            r_state <= n_state;
            r_tag   <= n_tag;
            if (i_cfg_valid && o_cfg_ready) begin
                r_target_count <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind     <= (req == REQ_PIXEL) ? KIND_PIXEL : KIND_MATCH;
            r_src_idx  <= i_entry_index;
            r_src_ok   <= ({1'b0, i_entry_index} < COUNT_W'(SOURCE_COLORS));
            r_pix_ok   <= ({1'b0, i_pixel_index} < COUNT_W'(SOURCE_COLORS));
            r_red      <= i_red;
            r_green    <= i_green;
            r_blue     <= i_blue;
            r_last     <= i_last_in;
            r_last_idx <= IDX_W'(count_clamped - COUNT_W'(1));
            r_scan_idx <= '0;
        end else if (r_state == S_SCAN) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
        if (emit) begin
            r_out_kind <= r_kind;
            if (r_kind == KIND_PIXEL) begin
                r_out_index <= r_pix_ok ? remap_rd_data : '0;
                r_out_dist  <= '0;
                r_out_last  <= r_last;
            end else begin
                r_out_index <= best_idx;
                r_out_dist  <= best_dist;
                r_out_last  <= 1'b0;
            end
        end
    end

    npr_target_ram u_target_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_accept && req == REQ_LOAD &&
                    ({1'b0, i_entry_index} < COUNT_W'(TARGET_COLORS))),
        .i_wr_addr (i_entry_index),
        .i_wr_data ({i_red, i_green, i_blue}),
        .i_rd_addr (r_scan_idx),
        .o_rd_data (target_rd_data)
    );

    npr_dist_unit u_dist_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (r_tag),
        .i_entry     (target_rd_data),
        .i_red       (r_red),
        .i_green     (r_green),
        .i_blue      (r_blue),
        .o_best_idx  (best_idx),
        .o_best_dist (best_dist),
        .o_done      (search_done)
    );

    // the match result is stored in the same cycle it is emitted
    npr_remap_ram u_remap_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (emit && r_kind == KIND_MATCH && r_src_ok),
        .i_wr_addr (r_src_idx),
        .i_wr_data (best_idx),
        .i_rd_en   (in_accept && req == REQ_PIXEL),
        .i_rd_addr (i_pixel_index),
        .o_rd_data (remap_rd_data)
    );

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_color_index = r_out_index;
    assign o_distance    = r_out_dist;
    assign o_last_out    = r_out_last;

endmodule
